@@ src/wbad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbad_pkg
// Shared widths, constants and types of the windowed block average decimator.
// ----------------------------------------------------------------------------
package wbad_pkg;

   // Record and register widths
   localparam int LANES          = 8;
   localparam int SAMPLE_BITS    = 32;
   localparam int COUNT_BITS     = 16;
   localparam int TIME_BITS      = 42;
   localparam int LIMIT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = TIME_BITS;

   // Accumulator widths, sized so a full window never overflows
   localparam int TIME_SUM_BITS    = TIME_BITS + COUNT_BITS;
   localparam int DENSITY_SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam int LANE_SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
   localparam int LANE_BITS        = $clog2(LANES);
   localparam int CURRENT_SUM_BITS = LANE_SUM_BITS + LANE_BITS;

   // Merge tree shape
   localparam int MERGE_LEVELS   = (LANES > 1) ? LANE_BITS : 1;
   localparam int MERGE_LEAVES   = 1 << MERGE_LEVELS;
   localparam int MERGE_CNT_BITS = (MERGE_LEVELS > 1) ? $clog2(MERGE_LEVELS) : 1;

   // Serial divider shape
   localparam int DIVIDEND_BITS = TIME_SUM_BITS;
   localparam int DIVISOR_BITS  = COUNT_BITS + LANE_BITS + 1;
   localparam int DIV_STEP_BITS = $clog2(DIVIDEND_BITS);

   // Length of one day in milliseconds
   localparam logic [TIME_BITS:0] DAY_MS = (TIME_BITS + 1)'(86400000);

   // Register reset values
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(2);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DAY_START    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LIMIT = CSR_INDEX_BITS'(1);

   typedef logic signed [LANE_SUM_BITS-1:0] lane_sum_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE,
      ST_MERGE,
      ST_FLUSH,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   // Accumulator control shared by the lanes and the top level sums
   typedef struct packed {
      logic add;
      logic clear;
   } acc_ctrl_type;

   // Divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ src/windowed_block_average_decimator.sv @@
`timescale 1ns / 1ps
// A request that closes a window passes through check, update, three merge-tree
//   levels, flush and 58 divider steps, then waits in delivery for a free output.
// A new request is taken only once the previous one is through; the bit-serial
//   dividers take the longest.
// Reset: synchronous, active high; clears sums, counters and the finished
//   flag, sets day_start to 0 and window_limit to 2.
// ----------------------------------------------------------------------------
// windowed_block_average_decimator
// Boxcar average and decimation of timestamped density and current records.
// ----------------------------------------------------------------------------
module windowed_block_average_decimator (
   input  logic                                    clock,
   input  logic                                    reset,
   // Request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [wbad_pkg::TIME_BITS-1:0]          req_sample_time,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_density_one,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_density_two,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_current_0,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_current_1,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_current_2,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_current_3,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_current_4,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_current_5,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_current_6,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_current_7,
   input  logic                                    req_final_record,
   // Response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [wbad_pkg::TIME_BITS-1:0]          rsp_mean_time,
   output logic signed [wbad_pkg::SAMPLE_BITS-1:0] rsp_mean_density_one,
   output logic signed [wbad_pkg::SAMPLE_BITS-1:0] rsp_mean_density_two,
   output logic signed [wbad_pkg::SAMPLE_BITS-1:0] rsp_mean_current,
   // Register write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [wbad_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wbad_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import wbad_pkg::*;

   state_type state_ff, state_in;

   // Captured request
   logic [TIME_BITS-1:0]          rec_time_ff;
   logic signed [SAMPLE_BITS-1:0] rec_d1_ff;
   logic signed [SAMPLE_BITS-1:0] rec_d2_ff;
   logic signed [SAMPLE_BITS-1:0] rec_cur_ff [LANES];
   logic                          rec_last_ff;

   // Registers
   logic [TIME_BITS-1:0]  day_start_ff, day_start_in;
   logic [TIME_BITS:0]    day_end_ff, day_end_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;

   // Window state
   logic [COUNT_BITS-1:0]              count_ff, count_in;
   logic [TIME_SUM_BITS-1:0]           time_sum_ff, time_sum_in;
   logic signed [DENSITY_SUM_BITS-1:0] d1_sum_ff, d1_sum_in;
   logic signed [DENSITY_SUM_BITS-1:0] d2_sum_ff, d2_sum_in;
   logic                               finished_ff, finished_in;
   logic [MERGE_CNT_BITS-1:0]          merge_cnt_ff, merge_cnt_in;

   // Decision flags, taken in the check cycle
   logic past_end_ff, in_day_ff, under_ff;
   logic [COUNT_BITS-1:0] count_inc;

   // Signs of the averaged sums
   logic neg_d1_ff, neg_d2_ff, neg_cur_ff;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [TIME_BITS-1:0]          rsp_time_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_d1_ff, rsp_d2_ff, rsp_cur_ff;

   // Control
   logic         accept;
   logic         do_sum, limit_hit, stop, flush_any, emit, out_free;
   logic         flags_load, div_start, rsp_load, finish_set;
   acc_ctrl_type acc_ctrl;

   // Lanes, merge and dividers
   lane_sum_type                     lane_sum [LANES];
   logic signed [CURRENT_SUM_BITS-1:0] cur_total;
   logic [DENSITY_SUM_BITS-1:0]      d1_mag, d2_mag;
   logic [CURRENT_SUM_BITS-1:0]      cur_mag;
   logic [DIVISOR_BITS-1:0]          div_count, div_count_lanes;
   logic [DIVIDEND_BITS-1:0]         q_time, q_d1, q_d2, q_cur;
   div_status_type                   st_time, st_d1, st_d2, st_cur;
   logic                             div_done;
   logic [SAMPLE_BITS-1:0]           mag_d1, mag_d2, mag_cur;

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign count_inc = count_ff + 1'b1;

   // Window decisions
   assign do_sum    = !finished_ff && !past_end_ff && in_day_ff && under_ff;
   assign limit_hit = !past_end_ff && in_day_ff && !under_ff;
   assign stop      = past_end_ff || rec_last_ff;
   assign flush_any = !finished_ff && (limit_hit || stop);
   assign emit      = flush_any && (count_ff != '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_done  = st_time.done && st_d1.done && st_d2.done && st_cur.done;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (merge_cnt_ff == MERGE_CNT_BITS'(MERGE_LEVELS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = emit ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_ready      = state_ff == ST_IDLE;
      flags_load     = state_ff == ST_CHECK;
      acc_ctrl.add   = (state_ff == ST_UPDATE) && do_sum;
      acc_ctrl.clear = (state_ff == ST_FLUSH) && flush_any;
      finish_set     = (state_ff == ST_FLUSH) && !finished_ff && stop;
      div_start      = (state_ff == ST_FLUSH) && emit;
      rsp_load       = (state_ff == ST_DELIVER) && out_free;
   end

   // Register writes
   always_comb begin
      day_start_in = day_start_ff;
      day_end_in   = day_end_ff;
      limit_in     = limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DAY_START: begin
               day_start_in = csr_data[TIME_BITS-1:0];
               day_end_in   = {1'b0, csr_data[TIME_BITS-1:0]} + DAY_MS;
            end
            CSR_WINDOW_LIMIT: begin
               limit_in = csr_data[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Window sums
   always_comb begin
      count_in    = count_ff;
      time_sum_in = time_sum_ff;
      d1_sum_in   = d1_sum_ff;
      d2_sum_in   = d2_sum_ff;
      priority if (acc_ctrl.clear) begin
         count_in    = '0;
         time_sum_in = '0;
         d1_sum_in   = '0;
         d2_sum_in   = '0;
      end else if (acc_ctrl.add) begin
         count_in    = count_inc;
         time_sum_in = time_sum_ff + TIME_SUM_BITS'(rec_time_ff);
         d1_sum_in   = d1_sum_ff + DENSITY_SUM_BITS'(rec_d1_ff);
         d2_sum_in   = d2_sum_ff + DENSITY_SUM_BITS'(rec_d2_ff);
      end
      finished_in  = finished_ff || finish_set;
      merge_cnt_in = (state_ff == ST_MERGE) ? merge_cnt_ff + 1'b1 : '0;
   end

   // Response register
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         day_start_ff <= '0;
         day_end_ff   <= DAY_MS;
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         time_sum_ff  <= '0;
         d1_sum_ff    <= '0;
         d2_sum_ff    <= '0;
         finished_ff  <= 1'b0;
         merge_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_start_ff <= day_start_in;
         day_end_ff   <= day_end_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         time_sum_ff  <= time_sum_in;
         d1_sum_ff    <= d1_sum_in;
         d2_sum_ff    <= d2_sum_in;
         finished_ff  <= finished_in;
         merge_cnt_ff <= merge_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         rec_time_ff   <= req_sample_time;
         rec_d1_ff     <= req_density_one;
         rec_d2_ff     <= req_density_two;
         rec_cur_ff[0] <= req_current_0;
         rec_cur_ff[1] <= req_current_1;
         rec_cur_ff[2] <= req_current_2;
         rec_cur_ff[3] <= req_current_3;
         rec_cur_ff[4] <= req_current_4;
         rec_cur_ff[5] <= req_current_5;
         rec_cur_ff[6] <= req_current_6;
         rec_cur_ff[7] <= req_current_7;
         rec_last_ff   <= req_final_record;
      end
   end

   // Day and window compares
   always_ff @(posedge clock) begin
      if (flags_load) begin
         past_end_ff <= {1'b0, rec_time_ff} >= day_end_ff;
         in_day_ff   <= rec_time_ff >= day_start_ff;
         under_ff    <= count_inc < limit_ff;
      end
   end

   // Current lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      wbad_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (acc_ctrl),
         .sample   (rec_cur_ff[g]),
         .lane_sum (lane_sum[g])
      );
   end

   wbad_merge u_merge (
      .clock    (clock),
      .lane_sum (lane_sum),
      .total    (cur_total)
   );

   // Magnitudes and divisors for the averages
   assign d1_mag  = d1_sum_ff[DENSITY_SUM_BITS-1] ? DENSITY_SUM_BITS'(-d1_sum_ff)
                                                  : DENSITY_SUM_BITS'(d1_sum_ff);
   assign d2_mag  = d2_sum_ff[DENSITY_SUM_BITS-1] ? DENSITY_SUM_BITS'(-d2_sum_ff)
                                                  : DENSITY_SUM_BITS'(d2_sum_ff);
   assign cur_mag = cur_total[CURRENT_SUM_BITS-1] ? CURRENT_SUM_BITS'(-cur_total)
                                                  : CURRENT_SUM_BITS'(cur_total);
   assign div_count       = DIVISOR_BITS'(count_ff);
   assign div_count_lanes = DIVISOR_BITS'(count_ff * LANES);

   always_ff @(posedge clock) begin
      if (div_start) begin
         neg_d1_ff  <= d1_sum_ff[DENSITY_SUM_BITS-1];
         neg_d2_ff  <= d2_sum_ff[DENSITY_SUM_BITS-1];
         neg_cur_ff <= cur_total[CURRENT_SUM_BITS-1];
      end
   end

   wbad_div u_div_time (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (time_sum_ff),
      .divisor  (div_count),
      .quotient (q_time),
      .status   (st_time)
   );

   wbad_div u_div_d1 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIVIDEND_BITS'(d1_mag)),
      .divisor  (div_count),
      .quotient (q_d1),
      .status   (st_d1)
   );

   wbad_div u_div_d2 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIVIDEND_BITS'(d2_mag)),
      .divisor  (div_count),
      .quotient (q_d2),
      .status   (st_d2)
   );

   wbad_div u_div_cur (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIVIDEND_BITS'(cur_mag)),
      .divisor  (div_count_lanes),
      .quotient (q_cur),
      .status   (st_cur)
   );

   // Restore signs; truncation toward zero falls out of dividing magnitudes
   assign mag_d1  = q_d1[SAMPLE_BITS-1:0];
   assign mag_d2  = q_d2[SAMPLE_BITS-1:0];
   assign mag_cur = q_cur[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_time_ff <= q_time[TIME_BITS-1:0];
         rsp_d1_ff   <= neg_d1_ff ? -mag_d1 : mag_d1;
         rsp_d2_ff   <= neg_d2_ff ? -mag_d2 : mag_d2;
         rsp_cur_ff  <= neg_cur_ff ? -mag_cur : mag_cur;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mean_time        = rsp_time_ff;
   assign rsp_mean_density_one = rsp_d1_ff;
   assign rsp_mean_density_two = rsp_d2_ff;
   assign rsp_mean_current     = rsp_cur_ff;

endmodule

@@ src/wbad_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbad_lane
// One current lane: keeps the running window sum of its own fast samples.
// ----------------------------------------------------------------------------
module wbad_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wbad_pkg::acc_ctrl_type                ctrl,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] sample,
   output wbad_pkg::lane_sum_type                lane_sum
);
   import wbad_pkg::*;

   lane_sum_type sum_ff;
   lane_sum_type sum_in;

   // Clear wins over add; the two never come together
   always_comb begin
      priority if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.add) begin
         sum_in = sum_ff + LANE_SUM_BITS'(sample);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign lane_sum = sum_ff;

endmodule

@@ src/wbad_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbad_merge
// Registered adder tree that folds the lane sums into one current sum.
// The root is valid once the lane sums have passed every registered level.
// ----------------------------------------------------------------------------
module wbad_merge (
   input  logic                                         clock,
   input  wbad_pkg::lane_sum_type                       lane_sum [wbad_pkg::LANES],
   output logic signed [wbad_pkg::CURRENT_SUM_BITS-1:0] total
);
   import wbad_pkg::*;

   logic signed [CURRENT_SUM_BITS-1:0] node_ff  [MERGE_LEAVES-1];
   logic signed [CURRENT_SUM_BITS-1:0] node_all [2*MERGE_LEAVES-1];

   // Heap layout: inner nodes first, then leaves padded with zero
   always_comb begin
      for (int i = 0; i < MERGE_LEAVES - 1; i++) begin
         node_all[i] = node_ff[i];
      end
      for (int j = 0; j < MERGE_LEAVES; j++) begin
         if (j < LANES) begin
            node_all[MERGE_LEAVES-1+j] = CURRENT_SUM_BITS'(lane_sum[j]);
         end else begin
            node_all[MERGE_LEAVES-1+j] = '0;
         end
      end
   end

   // One adder per inner node, each level registered
   always_ff @(posedge clock) begin
      for (int i = 0; i < MERGE_LEAVES - 1; i++) begin
         node_ff[i] <= node_all[2*i+1] + node_all[2*i+2];
      end
   end

   assign total = node_ff[0];

endmodule

@@ src/wbad_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbad_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wbad_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [wbad_pkg::DIVIDEND_BITS-1:0]  dividend,
   input  logic [wbad_pkg::DIVISOR_BITS-1:0]   divisor,
   output logic [wbad_pkg::DIVIDEND_BITS-1:0]  quotient,
   output wbad_pkg::div_status_type            status
);
   import wbad_pkg::*;

   logic [DIVIDEND_BITS-1:0] quot_ff, quot_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_BITS:0]    trial;
   logic                     fits;
   logic                     last_step;

   // Shift in the next dividend bit and try a subtract
   assign trial     = {rem_ff, quot_ff[DIVIDEND_BITS-1]};
   assign fits      = trial >= {1'b0, divisor_ff};
   assign last_step = step_ff == DIV_STEP_BITS'(DIVIDEND_BITS - 1);

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIVIDEND_BITS-2:0], fits};
         rem_in  = fits ? DIVISOR_BITS'(trial - {1'b0, divisor_ff})
                        : DIVISOR_BITS'(trial);
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ src/wbad_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbad_check
// Port-level checks of the decimator, bound to the top level.
// ----------------------------------------------------------------------------
module wbad_check (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic [wbad_pkg::TIME_BITS-1:0]          rsp_mean_time,
   input logic signed [wbad_pkg::SAMPLE_BITS-1:0] rsp_mean_density_one,
   input logic signed [wbad_pkg::SAMPLE_BITS-1:0] rsp_mean_density_two,
   input logic signed [wbad_pkg::SAMPLE_BITS-1:0] rsp_mean_current
);
   import wbad_pkg::*;

   // A stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mean_time)
         && $stable(rsp_mean_density_one) && $stable(rsp_mean_density_two)
         && $stable(rsp_mean_current))
      else $error("response payload changed while stalled");

   // An accepted request keeps the block busy through check and update and into merge
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("request taken while previous one in progress");

   // A new response only appears out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready, 1))
      else $error("response appeared without work in progress");

endmodule

bind windowed_block_average_decimator wbad_check u_wbad_check (.*);
